### src/hwcd_pkg.sv
// Package for the heartbeat worker chunk dispatcher.
// Holds table sizes, function and reply codes and the reply record.
// No dependencies.
package hwcd_pkg;

  localparam int WORKERS  = 16;
  localparam int CHUNKS   = 256;
  localparam int WIDX_W   = $clog2(WORKERS);
  localparam int WCNT_W   = $clog2(WORKERS + 1);
  localparam int CIDX_W   = $clog2(CHUNKS);
  localparam int CCNT_W   = $clog2(CHUNKS + 1);

  localparam logic [31:0] DISPATCH_RESET = 32'd500;
  localparam logic [15:0] TIMEOUT_RESET  = 16'd10;

  localparam logic [2:0] FUNC_TICK     = 3'd0;
  localparam logic [2:0] FUNC_REGISTER = 3'd1;
  localparam logic [2:0] FUNC_HEART    = 3'd2;
  localparam logic [2:0] FUNC_RESULT   = 3'd3;
  localparam logic [2:0] FUNC_SUBMIT   = 3'd4;

  localparam logic [2:0] KIND_REG_ACK   = 3'd0;
  localparam logic [2:0] KIND_HB_ACK    = 3'd1;
  localparam logic [2:0] KIND_RES_ACK   = 3'd2;
  localparam logic [2:0] KIND_ASSIGN    = 3'd3;
  localparam logic [2:0] KIND_JOB_DONE  = 3'd4;

  typedef struct packed {
    logic [2:0]  kind;
    logic [31:0] seq;
    logic [4:0]  target;
    logic [7:0]  chunk;
    logic [63:0] total;
  } reply_t;

endpackage

### src/hwcd_in_if.sv
// Input channel of the dispatcher: valid/ready plus one message item.
// No dependencies.
interface hwcd_in_if;
  logic        valid;
  logic        ready;
  logic [2:0]  func;
  logic [47:0] worker_address;
  logic [4:0]  worker_number;
  logic [7:0]  chunk_number;
  logic signed [63:0] chunk_value;
  logic [8:0]  chunk_total;
  logic        summing_job;
  logic [31:0] seq_number;

  modport source (output valid, func, worker_address, worker_number, chunk_number,
                  chunk_value, chunk_total, summing_job, seq_number, input ready);
  modport sink (input valid, func, worker_address, worker_number, chunk_number,
                chunk_value, chunk_total, summing_job, seq_number, output ready);
endinterface

### src/hwcd_out_if.sv
// Result channel of the dispatcher: valid/ready plus one reply item.
// No dependencies.
interface hwcd_out_if;
  logic        valid;
  logic        ready;
  logic [2:0]  reply_kind;
  logic [31:0] reply_seq;
  logic [4:0]  target_worker;
  logic [7:0]  assigned_chunk;
  logic signed [63:0] job_result;
  logic        last_reply;

  modport source (output valid, reply_kind, reply_seq, target_worker, assigned_chunk,
                  job_result, last_reply, input ready);
  modport sink (input valid, reply_kind, reply_seq, target_worker, assigned_chunk,
                job_result, last_reply, output ready);
endinterface

### src/heartbeat_worker_chunk_dispatcher_core.sv
// Heartbeat worker chunk dispatcher: worker and chunk tables in memories,
// scanned by one sequencer. Depends on hwcd_pkg, hwcd_in_if, hwcd_out_if.
//
//   channel | dir | handshake          | carries
//   in_ch   | in  | valid/ready        | one message item
//   out_ch  | out | valid/ready        | one reply item
//   cfg     | in  | cfg_we, cfg_wdata  | timeout_seconds
//
// One item at a time. An item passes through an accept step, a stale scan of
// the worker table, the chunk hand-out, a pass over the done chunks that sums
// their results, and a further worker scan for a register or result item.
// Each reply is held one deep and stalls the sequencer while both the held
// reply and the output register are full. Reset is synchronous; no clearing
// pass is needed.
module heartbeat_worker_chunk_dispatcher_core (
  input  logic             clk,
  input  logic             rst_n,
  hwcd_in_if.sink          in_ch,
  hwcd_out_if.source       out_ch,
  input  logic             cfg_we,
  input  logic [15:0]      cfg_wdata
);

  typedef enum logic [3:0] {
    S_IDLE, S_DROP_RD, S_DROP_EV, S_HAND, S_FIN_RD, S_FIN_AC, S_ITEM,
    S_SCAN_RD, S_SCAN_EV, S_REG_NEW, S_RES_ACK, S_END
  } state_t;

  state_t state_r;

  // latched item
  logic [2:0]  func_r;
  logic [47:0] addr_r;
  logic [4:0]  wnum_r;
  logic [7:0]  cnum_r;
  logic [63:0] cval_r;
  logic [8:0]  ctot_r;
  logic        sums_r;
  logic [31:0] seq_r;

  logic [15:0] timeout_r;
  logic [hwcd_pkg::WORKERS-1:0] live_r, busy_r;
  logic [hwcd_pkg::CHUNKS-1:0]  done_r, given_r;
  logic [hwcd_pkg::CCNT_W-1:0]  job_chunks_r;
  logic        job_running_r, job_sums_r;
  logic [31:0] job_seq_r, dispatch_seq_r, now_r;

  logic [hwcd_pkg::WCNT_W-1:0] w_r;
  logic [hwcd_pkg::CCNT_W-1:0] c_r;
  logic [63:0] total_r;
  logic [4:0]  target_r;

  hwcd_pkg::reply_t pend_r;
  logic             pend_valid_r;
  logic             out_valid_r;
  hwcd_pkg::reply_t out_r;
  logic             out_last_r;

  // memories
  logic [47:0] wmem_addr  [hwcd_pkg::WORKERS];
  logic [31:0] wmem_seen  [hwcd_pkg::WORKERS];
  logic [7:0]  wmem_chunk [hwcd_pkg::WORKERS];
  logic [63:0] cmem_res   [hwcd_pkg::CHUNKS];
  logic [47:0] addr_q;
  logic [31:0] seen_q;
  logic [7:0]  chunk_q;
  logic [63:0] res_q;

  logic [hwcd_pkg::WIDX_W-1:0] widx;
  logic [hwcd_pkg::CIDX_W-1:0] cidx;
  logic [hwcd_pkg::WIDX_W-1:0] hb_idx;
  assign widx   = w_r[hwcd_pkg::WIDX_W-1:0];
  assign cidx   = c_r[hwcd_pkg::CIDX_W-1:0];
  assign hb_idx = hwcd_pkg::WIDX_W'(wnum_r - 5'd1);

  always_ff @(posedge clk) begin
    addr_q  <= wmem_addr[widx];
    seen_q  <= wmem_seen[widx];
    chunk_q <= wmem_chunk[widx];
    res_q   <= cmem_res[cidx];
  end

  // lowest free and lowest empty worker
  logic                        free_any, empty_any;
  logic [hwcd_pkg::WIDX_W-1:0] free_idx, empty_idx;
  always_comb begin
    free_any  = 1'b0;
    empty_any = 1'b0;
    free_idx  = '0;
    empty_idx = '0;
    for (int i = hwcd_pkg::WORKERS - 1; i >= 0; i--) begin
      if (live_r[i] && !busy_r[i]) begin
        free_any = 1'b1;
        free_idx = hwcd_pkg::WIDX_W'(i);
      end
      if (!live_r[i]) begin
        empty_any = 1'b1;
        empty_idx = hwcd_pkg::WIDX_W'(i);
      end
    end
  end

  logic can_push, emit_ok;
  assign can_push = !out_valid_r || out_ch.ready;
  assign emit_ok  = !pend_valid_r || can_push;

  logic w_last, stale, match, hb_ok, res_store;
  assign w_last    = (w_r == hwcd_pkg::WCNT_W'(hwcd_pkg::WORKERS - 1));
  assign stale     = (now_r - seen_q) > {16'd0, timeout_r};
  assign match     = live_r[widx] && (addr_q == addr_r);
  assign hb_ok     = (wnum_r >= 5'd1) && (wnum_r <= 5'(hwcd_pkg::WORKERS))
                     && live_r[hb_idx];
  assign res_store = job_running_r
                     && ({1'b0, cnum_r} < hwcd_pkg::CCNT_W'(job_chunks_r));

  // reply request of the current cycle
  logic             emit_req;
  hwcd_pkg::reply_t emit_val;
  always_comb begin
    emit_req = 1'b0;
    emit_val = '0;
    unique case (state_r)
      S_HAND: begin
        if (job_running_r && c_r != job_chunks_r && !done_r[cidx] && !given_r[cidx]
            && free_any) begin
          emit_req        = 1'b1;
          emit_val.kind   = hwcd_pkg::KIND_ASSIGN;
          emit_val.seq    = dispatch_seq_r;
          emit_val.target = 5'(free_idx) + 5'd1;
          emit_val.chunk  = 8'(c_r);
        end
      end
      S_FIN_RD: begin
        if (job_running_r && c_r == job_chunks_r) begin
          emit_req       = 1'b1;
          emit_val.kind  = hwcd_pkg::KIND_JOB_DONE;
          emit_val.seq   = job_seq_r;
          emit_val.total = total_r;
        end
      end
      S_ITEM: begin
        if (func_r == hwcd_pkg::FUNC_HEART && hb_ok) begin
          emit_req        = 1'b1;
          emit_val.kind   = hwcd_pkg::KIND_HB_ACK;
          emit_val.seq    = seq_r;
          emit_val.target = wnum_r;
        end
      end
      S_REG_NEW: begin
        if (empty_any) begin
          emit_req        = 1'b1;
          emit_val.kind   = hwcd_pkg::KIND_REG_ACK;
          emit_val.seq    = seq_r;
          emit_val.target = 5'(empty_idx) + 5'd1;
        end
      end
      S_RES_ACK: begin
        emit_req        = 1'b1;
        emit_val.kind   = hwcd_pkg::KIND_RES_ACK;
        emit_val.seq    = seq_r;
        emit_val.target = target_r;
      end
      default: ;
    endcase
  end

  logic fire;
  assign fire = emit_req && emit_ok;

  // load the output register from the held reply
  logic out_load;
  assign out_load = pend_valid_r && (fire || (state_r == S_END && can_push));

  // memory writes
  always_ff @(posedge clk) begin
    if (state_r == S_HAND && fire) begin
      wmem_chunk[free_idx] <= 8'(c_r);
    end
    if (state_r == S_ITEM && func_r == hwcd_pkg::FUNC_HEART && fire) begin
      wmem_seen[hb_idx] <= now_r;
    end
    if (state_r == S_SCAN_EV && func_r == hwcd_pkg::FUNC_REGISTER && match) begin
      wmem_seen[widx] <= now_r;
    end
    if (state_r == S_REG_NEW && fire) begin
      wmem_addr[empty_idx] <= addr_r;
      wmem_seen[empty_idx] <= now_r;
    end
    if (state_r == S_ITEM && func_r == hwcd_pkg::FUNC_RESULT && res_store) begin
      cmem_res[cnum_r] <= cval_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r        <= S_IDLE;
      timeout_r      <= hwcd_pkg::TIMEOUT_RESET;
      live_r         <= '0;
      busy_r         <= '0;
      done_r         <= '0;
      given_r        <= '0;
      job_chunks_r   <= '0;
      job_running_r  <= 1'b0;
      job_sums_r     <= 1'b0;
      job_seq_r      <= '0;
      dispatch_seq_r <= hwcd_pkg::DISPATCH_RESET;
      now_r          <= '0;
      pend_valid_r   <= 1'b0;
      out_valid_r    <= 1'b0;
      w_r            <= '0;
      c_r            <= '0;
    end else begin
      if (cfg_we) timeout_r <= cfg_wdata;
      if (out_load) out_valid_r <= 1'b1;
      else if (out_ch.ready) out_valid_r <= 1'b0;

      unique case (state_r)
        S_IDLE: begin
          if (in_ch.valid) begin
            func_r  <= in_ch.func;
            addr_r  <= in_ch.worker_address;
            wnum_r  <= in_ch.worker_number;
            cnum_r  <= in_ch.chunk_number;
            cval_r  <= in_ch.chunk_value;
            ctot_r  <= in_ch.chunk_total;
            sums_r  <= in_ch.summing_job;
            seq_r   <= in_ch.seq_number;
            total_r <= '0;
            w_r     <= '0;
            state_r <= S_DROP_RD;
          end
        end
        S_DROP_RD: state_r <= S_DROP_EV;
        S_DROP_EV: begin
          if (live_r[widx] && stale) begin
            live_r[widx] <= 1'b0;
            if (busy_r[widx] && job_running_r) given_r[chunk_q] <= 1'b0;
          end
          w_r <= w_r + 1'b1;
          if (w_last) begin
            c_r     <= '0;
            state_r <= S_HAND;
          end else begin
            state_r <= S_DROP_RD;
          end
        end
        S_HAND: begin
          priority if (!job_running_r || c_r == job_chunks_r) begin
            c_r     <= '0;
            state_r <= S_FIN_RD;
          end else if (done_r[cidx] || given_r[cidx]) begin
            c_r <= c_r + 1'b1;
          end else if (!free_any) begin
            c_r     <= '0;
            state_r <= S_FIN_RD;
          end else if (fire) begin
            dispatch_seq_r   <= dispatch_seq_r + 32'd1;
            busy_r[free_idx] <= 1'b1;
            given_r[cidx]    <= 1'b1;
            c_r              <= c_r + 1'b1;
          end
        end
        S_FIN_RD: begin
          priority if (!job_running_r) begin
            state_r <= S_ITEM;
          end else if (c_r == job_chunks_r) begin
            if (fire) begin
              job_running_r <= 1'b0;
              job_chunks_r  <= '0;
              state_r       <= S_ITEM;
            end
          end else if (!done_r[cidx]) begin
            state_r <= S_ITEM;
          end else begin
            state_r <= S_FIN_AC;
          end
        end
        S_FIN_AC: begin
          if (job_sums_r) total_r <= total_r + res_q;
          c_r     <= c_r + 1'b1;
          state_r <= S_FIN_RD;
        end
        S_ITEM: begin
          w_r      <= '0;
          target_r <= '0;
          unique case (func_r)
            hwcd_pkg::FUNC_TICK: begin
              now_r   <= now_r + 32'd1;
              state_r <= S_END;
            end
            hwcd_pkg::FUNC_REGISTER: state_r <= S_SCAN_RD;
            hwcd_pkg::FUNC_HEART: begin
              if (!hb_ok || fire) state_r <= S_END;
            end
            hwcd_pkg::FUNC_RESULT: begin
              if (res_store) done_r[cnum_r] <= 1'b1;
              state_r <= S_SCAN_RD;
            end
            hwcd_pkg::FUNC_SUBMIT: begin
              job_seq_r     <= seq_r;
              job_chunks_r  <= (ctot_r > 9'(hwcd_pkg::CHUNKS))
                               ? hwcd_pkg::CCNT_W'(hwcd_pkg::CHUNKS)
                               : hwcd_pkg::CCNT_W'(ctot_r);
              done_r        <= '0;
              given_r       <= '0;
              job_sums_r    <= sums_r;
              job_running_r <= 1'b1;
              state_r       <= S_END;
            end
            default: state_r <= S_END;
          endcase
        end
        S_SCAN_RD: state_r <= S_SCAN_EV;
        S_SCAN_EV: begin
          w_r <= w_r + 1'b1;
          if (func_r == hwcd_pkg::FUNC_REGISTER) begin
            priority if (match) state_r <= S_END;
            else if (w_last) state_r <= S_REG_NEW;
            else state_r <= S_SCAN_RD;
          end else begin
            if (match) begin
              busy_r[widx] <= 1'b0;
              if (target_r == 5'd0) target_r <= 5'(widx) + 5'd1;
            end
            state_r <= w_last ? S_RES_ACK : S_SCAN_RD;
          end
        end
        S_REG_NEW: begin
          if (!empty_any) begin
            state_r <= S_END;
          end else if (fire) begin
            live_r[empty_idx] <= 1'b1;
            busy_r[empty_idx] <= 1'b0;
            state_r           <= S_END;
          end
        end
        S_RES_ACK: begin
          if (fire) state_r <= S_END;
        end
        S_END: begin
          // flush the held reply as the final one of this item
          if (!pend_valid_r) begin
            state_r <= S_IDLE;
          end else if (can_push) begin
            out_r        <= pend_r;
            out_last_r   <= 1'b1;
            pend_valid_r <= 1'b0;
            state_r      <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase

      // hold each new reply one deep so the last one can be flagged
      if (fire) begin
        if (pend_valid_r) begin
          out_r       <= pend_r;
          out_last_r  <= 1'b0;
        end
        pend_r       <= emit_val;
        pend_valid_r <= 1'b1;
      end
    end
  end

  assign in_ch.ready           = (state_r == S_IDLE);
  assign out_ch.valid          = out_valid_r;
  assign out_ch.reply_kind     = out_r.kind;
  assign out_ch.reply_seq      = out_r.seq;
  assign out_ch.target_worker  = out_r.target;
  assign out_ch.assigned_chunk = out_r.chunk;
  assign out_ch.job_result     = out_r.total;
  assign out_ch.last_reply     = out_last_r;

`ifndef SYNTHESIS
  a_idle_no_pend: assert property (@(posedge clk) disable iff (!rst_n)
    in_ch.ready |-> !pend_valid_r) else $error("reply left pending at idle");
  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (in_ch.valid && in_ch.ready) |=> (state_r == S_DROP_RD))
    else $error("item accepted without starting the scan");
  a_chunks_range: assert property (@(posedge clk) disable iff (!rst_n)
    job_chunks_r <= hwcd_pkg::CCNT_W'(hwcd_pkg::CHUNKS))
    else $error("job chunk count out of range");
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    (fire && pend_valid_r) |-> can_push) else $error("output register overwritten");
`endif

endmodule
